// File: design/rsi_pkg.sv
package rsi_pkg;

  // Fixed field widths.
  localparam int COORD_W   = 32;
  localparam int DIR_W     = 16;
  localparam int RADIUS_W  = 31;
  localparam int DIR_FRAC  = 14;
  localparam int CFG_IDX_W = 2;

  // Default fraction bits of the coordinate format.
  localparam int FRAC_BITS_DEF = 16;

  // Internal widths of the datapath.
  localparam int DIFF_W = COORD_W + 1;            // centre minus origin
  localparam int PROD_W = DIFF_W + DIR_W;         // one term of the dot product
  localparam int DOT_W  = PROD_W + 2;             // sum of three terms
  localparam int T_W    = DOT_W - DIR_FRAC;       // projection length
  localparam int DT_W   = T_W + DIR_W;            // direction times length
  localparam int P_W    = DT_W - DIR_FRAC + 1;    // closest point
  localparam int DV_W   = P_W + 1;                // closest point minus centre
  localparam int SQ_W   = 2 * RADIUS_W;           // squared magnitudes
  localparam int D2_W   = SQ_W + 2;               // sum of three squares
  localparam int H_W    = RADIUS_W;               // square root result
  localparam int HD_W   = H_W + 1 + DIR_W;        // direction times root
  localparam int E_W    = P_W + 1;                // entry point before saturation

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic                    hit;
    logic signed [P_W-1:0]   p_x;
    logic signed [P_W-1:0]   p_y;
    logic signed [P_W-1:0]   p_z;
    logic signed [DIR_W-1:0] d_x;
    logic signed [DIR_W-1:0] d_y;
    logic signed [DIR_W-1:0] d_z;
  } rsi_side_t;

endpackage

// File: design/rsi_isqrt.sv
module rsi_isqrt #(
  parameter int IN_W   = 62,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int ROOT_W = IN_W / 2;

  // One result bit per stage, restoring digit-by-digit method.
  logic              v_r    [ROOT_W];
  logic [ROOT_W:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] q_r    [ROOT_W];
  logic [IN_W-1:0]   n_r    [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_in;
      logic [ROOT_W:0]   rem_in;
      logic [ROOT_W-1:0] q_in;
      logic [IN_W-1:0]   n_in;
      logic [SIDE_W-1:0] side_in;
      logic [ROOT_W+2:0] rem_sh;
      logic [ROOT_W+2:0] trial;
      logic              ge;
      logic [ROOT_W:0]   rem_nxt;
      logic [ROOT_W-1:0] q_nxt;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = '0;
        assign q_in    = '0;
        assign n_in    = in_radicand;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = v_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign q_in    = q_r[k-1];
        assign n_in    = n_r[k-1];
        assign side_in = side_r[k-1];
      end

      always_comb begin
        rem_sh  = {rem_in, n_in[IN_W-1 -: 2]};
        trial   = {1'b0, q_in, 2'b01};
        ge      = (rem_sh >= trial);
        rem_nxt = ge ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
        q_nxt   = {q_in[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
        if (en) begin
          rem_r[k]  <= rem_nxt;
          q_r[k]    <= q_nxt;
          n_r[k]    <= {n_in[IN_W-3:0], 2'b00};
          side_r[k] <= side_in;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = q_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// File: design/ray_sphere_intersect.sv
// Channel   Beat contents (lowest bits first)                       Handshake
// in_       tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z tvalid/tready
// out_      tdata: entry_x, entry_y, entry_z; tuser: hit            tvalid/tready
// cfg_      wr_en, index, wdata (center_x/y/z, sphere_radius)      write only
//
// One ray enters per cycle while the output is not stalled; a result passes through
// 12 arithmetic stages plus one per bit of the 31-bit square root.
// Reset (synchronous, active low) empties the pipeline and loads a unit radius
// and a centre at the origin.
// A stall at the output holds every stage at once; in_tready follows it.
module ray_sphere_intersect #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [143:0]                      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // entry_x, entry_y, entry_z
  output logic [95:0]                       out_tdata,
  // hit
  output logic                              out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsi_pkg::COORD_W-1:0]       cfg_wdata
);

  import rsi_pkg::*;

  localparam int ROOT_STAGES = H_W;

  // Configuration.
  logic signed [COORD_W-1:0] c_r [3];
  logic [RADIUS_W-1:0]       r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r[0] <= '0;
      c_r[1] <= '0;
      c_r[2] <= '0;
      r_r    <= RADIUS_W'(64'd1 << FRAC_BITS);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CENTER_X: c_r[0] <= cfg_wdata;
        CFG_CENTER_Y: c_r[1] <= cfg_wdata;
        CFG_CENTER_Z: c_r[2] <= cfg_wdata;
        CFG_RADIUS:   r_r    <= cfg_wdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic signed [COORD_W-1:0] o_in [3];
  logic signed [DIR_W-1:0]   d_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_in[i] = in_tdata[i*COORD_W +: COORD_W];
      d_in[i] = in_tdata[3*COORD_W + i*DIR_W +: DIR_W];
    end
  end

  logic [10:1] v_r;

  logic signed [DIFF_W-1:0]  diff_r [3];
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [T_W-1:0]     t_r;
  logic signed [DT_W-1:0]    dt_r   [3];
  logic signed [P_W-1:0]     p5_r   [3];
  logic signed [DV_W-1:0]    dv_r   [3];
  logic [RADIUS_W-1:0]       a_r    [3];
  logic [SQ_W-1:0]           sq_r   [3];
  logic [SQ_W-1:0]           r2_8_r;
  logic [SQ_W-1:0]           r2_9_r;
  logic [D2_W-1:0]           d2_r;
  logic                      far7_r, far8_r, far9_r;
  logic [SQ_W-1:0]           rad_r;
  rsi_side_t                 side10_r;

  // Origin, direction and point carried between arithmetic stages.
  logic signed [COORD_W-1:0] o1_r [3], o2_r [3], o3_r [3], o4_r [3];
  logic signed [DIR_W-1:0]   d1_r [3], d2d_r [3], d3_r [3], d4_r [3], d5_r [3];
  logic signed [DIR_W-1:0]   d6_r [3], d7_r [3], d8_r [3], d9_r [3];
  logic signed [P_W-1:0]     p6_r [3], p7_r [3], p8_r [3], p9_r [3];

  logic signed [DOT_W-1:0]   dot;
  logic signed [DV_W-1:0]    dv_abs [3];
  logic                      far;
  logic [D2_W-1:0]           d2_sum;
  logic                      hit10;

  always_comb begin
    dot = DOT_W'(prod_r[0]) + DOT_W'(prod_r[1]) + DOT_W'(prod_r[2]);
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dv_abs[i] = dv_r[i][DV_W-1] ? -dv_r[i] : dv_r[i];
      if (DV_W'(dv_abs[i]) > DV_W'({1'b0, r_r})) begin
        far = 1'b1;
      end
    end
    d2_sum = D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);
    hit10  = !far9_r && (d2_r <= D2_W'(r2_9_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[9:1], in_tvalid};
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // Stage 1: centre minus origin.
        diff_r[i] <= DIFF_W'(c_r[i]) - DIFF_W'(o_in[i]);
        o1_r[i]   <= o_in[i];
        d1_r[i]   <= d_in[i];
        // Stage 2: terms of the dot product.
        prod_r[i] <= PROD_W'(diff_r[i]) * PROD_W'(d1_r[i]);
        o2_r[i]   <= o1_r[i];
        d2d_r[i]  <= d1_r[i];
        // Stage 3 carries; the sum is below.
        o3_r[i]   <= o2_r[i];
        d3_r[i]   <= d2d_r[i];
        // Stage 4: direction scaled by t.
        dt_r[i]   <= DT_W'(d3_r[i]) * DT_W'(t_r);
        o4_r[i]   <= o3_r[i];
        d4_r[i]   <= d3_r[i];
        // Stage 5: closest point.
        p5_r[i]   <= P_W'(o4_r[i]) + P_W'($signed(dt_r[i][DT_W-1:DIR_FRAC]));
        d5_r[i]   <= d4_r[i];
        // Stage 6: offset from the centre.
        dv_r[i]   <= DV_W'(p5_r[i]) - DV_W'(c_r[i]);
        p6_r[i]   <= p5_r[i];
        d6_r[i]   <= d5_r[i];
        // Stage 7: magnitudes.
        a_r[i]    <= dv_abs[i][RADIUS_W-1:0];
        p7_r[i]   <= p6_r[i];
        d7_r[i]   <= d6_r[i];
        // Stage 8: squares.
        sq_r[i]   <= SQ_W'(a_r[i]) * SQ_W'(a_r[i]);
        p8_r[i]   <= p7_r[i];
        d8_r[i]   <= d7_r[i];
        p9_r[i]   <= p8_r[i];
        d9_r[i]   <= d8_r[i];
      end
      t_r      <= dot[DOT_W-1:DIR_FRAC];
      far7_r   <= far;
      far8_r   <= far7_r;
      r2_8_r   <= SQ_W'(r_r) * SQ_W'(r_r);
      far9_r   <= far8_r;
      r2_9_r   <= r2_8_r;
      d2_r     <= d2_sum;
      // Stage 10: hit decision and radicand.
      rad_r          <= hit10 ? SQ_W'(D2_W'(r2_9_r) - d2_r) : '0;
      side10_r.hit   <= hit10;
      side10_r.p_x   <= p9_r[0];
      side10_r.p_y   <= p9_r[1];
      side10_r.p_z   <= p9_r[2];
      side10_r.d_x   <= d9_r[0];
      side10_r.d_y   <= d9_r[1];
      side10_r.d_z   <= d9_r[2];
    end
  end

  logic            sq_valid;
  logic [H_W-1:0]  sq_root;
  rsi_side_t       sq_side;

  rsi_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W ($bits(rsi_side_t))
  ) u_isqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v_r[10]),
    .in_radicand (rad_r),
    .in_side     (side10_r),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_side    (sq_side)
  );

  // Stage 11: direction scaled by the root.
  logic                   v11_r;
  logic signed [HD_W-1:0] hd_r [3];
  rsi_side_t              side11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else if (en) begin
      v11_r <= sq_valid;
    end
    if (en) begin
      hd_r[0]  <= HD_W'(sq_side.d_x) * $signed({1'b0, sq_root});
      hd_r[1]  <= HD_W'(sq_side.d_y) * $signed({1'b0, sq_root});
      hd_r[2]  <= HD_W'(sq_side.d_z) * $signed({1'b0, sq_root});
      side11_r <= sq_side;
    end
  end

  // Stage 12: entry point, saturated, into the output register.
  logic signed [P_W-1:0]     p11 [3];
  logic signed [E_W-1:0]     e_full [3];
  logic signed [COORD_W-1:0] e_sat [3];
  logic [95:0]               out_data_nxt;
  logic [95:0]               out_data_r;
  logic                      out_hit_r;

  always_comb begin
    p11[0] = side11_r.p_x;
    p11[1] = side11_r.p_y;
    p11[2] = side11_r.p_z;
    for (int i = 0; i < 3; i++) begin
      e_full[i] = E_W'(p11[i]) - E_W'($signed(hd_r[i][HD_W-1:DIR_FRAC]));
      if (e_full[i] > E_W'(32'sh7fffffff)) begin
        e_sat[i] = 32'sh7fffffff;
      end else if (e_full[i] < -E_W'(33'sh080000000)) begin
        e_sat[i] = 32'sh80000000;
      end else begin
        e_sat[i] = e_full[i][COORD_W-1:0];
      end
      out_data_nxt[i*COORD_W +: COORD_W] = side11_r.hit ? e_sat[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v11_r;
    end
    if (en) begin
      out_data_r <= out_data_nxt;
      out_hit_r  <= side11_r.hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero entry point");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v_r, v11_r, sq_valid}))
    else $error("pipeline moved during a stall");

endmodule

// File: dv/tb_ray_sphere_intersect.sv
`timescale 1ns / 100ps

module tb_ray_sphere_intersect;
  import rsi_pkg::*;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] ex, ey, ez;
  } entry_t;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  class hit_scoreboard;
    longint          ctr[3];
    longint unsigned radius;
    entry_t          pending[$];
    int              mismatches;

    function void reset_regs();
      ctr[0] = 0;
      ctr[1] = 0;
      ctr[2] = 0;
      radius = 64'd1 << 16;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_CENTER_X: ctr[0] = longint'($signed(val));
        CFG_CENTER_Y: ctr[1] = longint'($signed(val));
        CFG_CENTER_Z: ctr[2] = longint'($signed(val));
        CFG_RADIUS:   radius = {33'd0, val[30:0]};
        default: ;
      endcase
    endfunction

    // Closest point on the line, then step back by sqrt(r^2 - d^2) along it.
    function void note_ray(ray_t r);
      longint          o[3], d[3], p[3], dv[3], dot, t, h;
      longint unsigned a, d2, r2;
      entry_t          e;
      bit              miss;
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      dot = 0;
      d2 = 0;
      miss = 0;
      e = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
      for (int i = 0; i < 3; i++) dot += (ctr[i] - o[i]) * d[i];
      t = dot >>> DIR_FRAC;
      for (int i = 0; i < 3; i++) begin
        p[i] = o[i] + ((d[i] * t) >>> DIR_FRAC);
        dv[i] = p[i] - ctr[i];
        a = dv[i] < 0 ? -dv[i] : dv[i];
        if (a > radius) miss = 1;
      end
      if (!miss) begin
        for (int i = 0; i < 3; i++) begin
          a = dv[i] < 0 ? -dv[i] : dv[i];
          d2 += a * a;
        end
        r2 = radius * radius;
        if (d2 <= r2) begin
          h = int_sqrt(r2 - d2);
          e.hit = 1;
          e.ex = clamp32(p[0] - ((d[0] * h) >>> DIR_FRAC));
          e.ey = clamp32(p[1] - ((d[1] * h) >>> DIR_FRAC));
          e.ez = clamp32(p[2] - ((d[2] * h) >>> DIR_FRAC));
        end
      end
      pending.push_back(e);
    endfunction

    function void check(entry_t got);
      entry_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hit=%0d %0d %0d %0d",
                   got.hit, got.ex, got.ey, got.ez);
        return;
      end
      want = pending.pop_front();
      if (want.hit !== got.hit || want.ex !== got.ex || want.ey !== got.ey ||
          want.ez !== got.ez) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hit=%0d %0d %0d %0d, got hit=%0d %0d %0d %0d",
                   want.hit, want.ex, want.ey, want.ez,
                   got.hit, got.ex, got.ey, got.ez);
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_tvalid = 0;
  logic                 in_tready;
  logic [143:0]         in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 0;
  logic [95:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CENTER_X;
  logic [31:0]          cfg_wdata = '0;

  hit_scoreboard sb = new();
  bit            no_idle = 0;
  bit            hold_req = 0;
  longint        cycles = 0;

  ray_sphere_intersect dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.set_reg(idx, val);
  endtask

  // Leaves the bus at a falling edge right after the beat was taken.
  task automatic send_ray(ray_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
    do @(posedge clk); while (!in_tready);
    sb.note_ray(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
    // The pipeline is 43 stages deep.
    repeat (60) @(negedge clk);
  endtask

  // Mostly rays aimed near the centre with a unit direction, some noise.
  function automatic ray_t aimed_ray();
    ray_t   r;
    longint span, off[3];
    real    v[3], n;
    span = sb.radius * 3 + 16;
    for (int i = 0; i < 3; i++) begin
      off[i] = longint'($urandom_range(0, 2 * 65535)) * (span / 65536 + 1) - span;
      off[i] = off[i] < -span ? -span : off[i];
    end
    r.ox = clamp32(sb.ctr[0] + off[0]);
    r.oy = clamp32(sb.ctr[1] + off[1]);
    r.oz = clamp32(sb.ctr[2] + off[2]);
    for (int i = 0; i < 3; i++)
      v[i] = -real'(off[i]) + (real'($urandom_range(0, 2000)) - 1000.0) * real'(span) / 2000.0;
    n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
    if (n == 0.0) n = 1.0;
    r.dx = 16'($rtoi(v[0] / n * 16383.0));
    r.dy = 16'($rtoi(v[1] / n * 16383.0));
    r.dz = 16'($rtoi(v[2] / n * 16383.0));
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = $urandom;
    r.oy = $urandom;
    r.oz = $urandom;
    r.dx = 16'($signed($urandom_range(0, 32768)) - 16384);
    r.dy = 16'($signed($urandom_range(0, 32768)) - 16384);
    r.dz = 16'($signed($urandom_range(0, 32768)) - 16384);
    return r;
  endfunction

  initial begin : receiver
    entry_t got;
    int     stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 0;
        hold_req = 0;
        repeat (300) @(negedge clk);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_tready <= 0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      got.hit = out_tuser;
      got.ex = out_tdata[31:0];
      got.ey = out_tdata[63:32];
      got.ez = out_tdata[95:64];
      sb.check(got);
    end
  end

  initial begin : stimulus
    ray_t r;
    logic [31:0] cx[6], cy[6], cz[6], rad[6];
    sb.reset_regs();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed rays under the reset sphere: unit sphere at the origin.
    r = '{32'sh0, 32'sh0, -32'sh50000, 16'sh0, 16'sh0, 16'sh4000}; send_ray(r);
    r = '{32'sh0, 32'sh0, 32'sh50000, 16'sh0, 16'sh0, -16'sh4000}; send_ray(r);
    r = '{32'sh10000, 32'sh0, -32'sh50000, 16'sh0, 16'sh0, 16'sh4000}; send_ray(r);
    r = '{32'sh20000, 32'sh0, -32'sh50000, 16'sh0, 16'sh0, 16'sh4000}; send_ray(r);
    r = '{32'sh8000, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0}; send_ray(r);
    r = '{32'sh20000, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0}; send_ray(r);
    r = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          -16'sh4000, -16'sh4000, -16'sh4000}; send_ray(r);
    r = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          16'sh4000, 16'sh4000, 16'sh4000}; send_ray(r);
    r = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -16'sh4000, 16'sh4000, 16'sh0}; send_ray(r);
    r = '{-32'sh50000, 32'sh4000, 32'sh4000, 16'sh4000, 16'sh0, 16'sh0}; send_ray(r);
    r = '{32'sh0, 32'sh0, 32'sh0, 16'sh2d41, 16'sh2d41, 16'sh0}; send_ray(r);
    r = '{32'shffff, 32'shffff, 32'shffff, -16'sh1, 16'sh1, -16'sh4000}; send_ray(r);
    drain();

    // Extreme spheres first, then random ones.
    cx[0] = 32'h7fffffff; cy[0] = 32'h80000000; cz[0] = 32'h7fffffff; rad[0] = 32'hffffffff;
    cx[1] = 32'h0;        cy[1] = 32'h0;        cz[1] = 32'h0;        rad[1] = 32'h0;
    cx[2] = 32'h80000000; cy[2] = 32'h80000000; cz[2] = 32'h80000000; rad[2] = 32'h7fffffff;
    for (int k = 3; k < 6; k++) begin
      cx[k] = $urandom;
      cy[k] = $urandom;
      cz[k] = $urandom;
      rad[k] = $urandom_range(1, 32'h400000);
    end

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_CENTER_X, cx[ph]);
      cfg_write(CFG_CENTER_Y, cy[ph]);
      cfg_write(CFG_CENTER_Z, cz[ph]);
      cfg_write(CFG_RADIUS, rad[ph]);
      // Zero radius: a few rays through the exact centre.
      if (ph == 1) begin
        r = '{32'sh0, 32'sh0, -32'sh10000, 16'sh0, 16'sh0, 16'sh4000}; send_ray(r);
        r = '{32'sh0, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0}; send_ray(r);
      end
      if (ph == 3) hold_req = 1;
      for (int n = 0; n < 250; n++) begin
        no_idle = (n % 100) >= 70;
        send_ray($urandom_range(0, 9) < 7 ? aimed_ray() : noise_ray());
      end
      no_idle = 0;
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
design/rsi_pkg.sv
design/rsi_isqrt.sv
design/ray_sphere_intersect.sv
dv/tb_ray_sphere_intersect.sv
